[design/compacting_value_list_macros.svh]
// Assertion macros for the compacting value list.
`ifndef COMPACTING_VALUE_LIST_MACROS_SVH
`define COMPACTING_VALUE_LIST_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge out of reset.
`define CVL_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("compacting_value_list: check failed");

// Next-cycle implication.
`define CVL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("compacting_value_list: check failed");

`else

`define CVL_ASSERT(label, ante, cons)
`define CVL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[design/cvl_pkg.sv]
// Shared codes and types of the compacting value list.
package cvl_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned PosW   = 6;
  localparam int unsigned TotalW = 7;

  localparam logic [1:0] OP_APPEND       = 2'd0;
  localparam logic [1:0] OP_SEARCH       = 2'd1;
  localparam logic [1:0] OP_REMOVE_FIRST = 2'd2;
  localparam logic [1:0] OP_REMOVE_ALL   = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;  // every cell takes the word of its right neighbor (the last cell keeps its own), unless written
    logic write;  // the cell at the tail index takes the write word
  } cell_ctrl_t;

endpackage

[design/cvl_cell.sv]
// One list cell: holds one entry and passes it toward the head.
module cvl_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 6
) (
  input  logic                              clk_i,
  input  cvl_pkg::cell_ctrl_t               ctrl_i,
  input  logic [IW-1:0]                     tail_i,
  input  logic signed [cvl_pkg::ValW-1:0]   wr_data_i,
  input  logic signed [cvl_pkg::ValW-1:0]   right_i,
  output logic signed [cvl_pkg::ValW-1:0]   data_o
);

  logic signed [cvl_pkg::ValW-1:0] data_q, data_d;
  logic                            hit;

  assign hit = ctrl_i.write && (tail_i == IW'(IDX));

  always_comb begin
    if (hit) begin
      data_d = wr_data_i;
    end else if (ctrl_i.shift) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[design/compacting_value_list.sv]
// Append registers its result in the cycle after accept; search and both removes
// sweep the n entries present at accept, then register the result; the list rotates through
// the head cell one entry per cycle and kept entries go back to the tail in order.
// One request is handled at a time; the input stalls while a sweep runs or while a
// finished result waits under a stall.
// Reset clears the entry count, control state and output valid; cells stay undefined.
`include "compacting_value_list_macros.svh"

module compacting_value_list #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        operation_i,
  input  logic signed [cvl_pkg::ValW-1:0]   value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic [cvl_pkg::PosW-1:0]          position_o,
  output logic [cvl_pkg::TotalW-1:0]        removed_count_o,
  output logic [cvl_pkg::TotalW-1:0]        entry_total_o,
  output logic                              is_full_o,
  output logic                              is_empty_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] removed_q, removed_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          found_q, found_d;
  logic [1:0]    op_q, op_d;
  logic signed [cvl_pkg::ValW-1:0] val_q, val_d;

  logic                              out_valid_q;
  logic [1:0]                        status_q, status_d;
  logic [cvl_pkg::PosW-1:0]          opos_q, opos_d;
  logic [cvl_pkg::TotalW-1:0]        orem_q, orem_d;
  logic [cvl_pkg::TotalW-1:0]        otot_q, otot_d;
  logic                              ofull_q, ofull_d;
  logic                              oempty_q, oempty_d;

  logic                 accept;
  logic                 emit;
  logic                 head_match;
  logic                 drop;
  logic [CW-1:0]        count_m1;
  logic [IW-1:0]        tail;
  logic signed [cvl_pkg::ValW-1:0] wr_data;
  cvl_pkg::cell_ctrl_t  ctrl;
  logic [1:0]           res_status;
  logic [CW-1:0]        res_pos;
  logic [CW-1:0]        res_removed;
  logic [CW+cvl_pkg::TotalW-1:0] tot_ext, rem_ext;
  logic [CW+cvl_pkg::PosW-1:0]   pos_ext;

  logic signed [cvl_pkg::ValW-1:0] cell_data [CAPACITY];

  // Row of cells: each hands its entry to the left neighbor on a shift.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [cvl_pkg::ValW-1:0] right;
    if (g == CAPACITY - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid
      assign right = cell_data[g+1];
    end
    cvl_cell #(
      .IDX(g),
      .IW (IW)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .tail_i   (tail),
      .wr_data_i(wr_data),
      .right_i  (right),
      .data_o   (cell_data[g])
    );
  end

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign count_m1   = count_q - CW'(1);
  assign head_match = (cell_data[0] == val_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    k_d         = k_q;
    removed_d   = removed_q;
    pos_d       = pos_q;
    found_d     = found_q;
    op_d        = op_q;
    val_d       = val_q;
    ctrl        = '0;
    tail        = count_q[IW-1:0];
    wr_data     = value_i;
    drop        = 1'b0;
    emit        = 1'b0;
    res_status  = cvl_pkg::ST_DONE;
    res_pos     = '0;
    res_removed = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == cvl_pkg::OP_APPEND) begin
            emit = 1'b1;
            if (count_q >= CW'(CAPACITY)) begin
              res_status = cvl_pkg::ST_FULL;
            end else begin
              ctrl.write = 1'b1;
              res_pos    = count_q;
              count_d    = count_q + CW'(1);
            end
          end else begin
            op_d      = operation_i;
            val_d     = value_i;
            n_d       = count_q;
            k_d       = '0;
            removed_d = '0;
            pos_d     = '0;
            found_d   = 1'b0;
            state_d   = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (k_q == n_q) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          if (op_q == cvl_pkg::OP_SEARCH) begin
            res_status = found_q ? cvl_pkg::ST_DONE : cvl_pkg::ST_NOT_FOUND;
            res_pos    = found_q ? pos_q : '0;
          end else begin
            res_status  = (removed_q != '0) ? cvl_pkg::ST_DONE : cvl_pkg::ST_NOT_FOUND;
            res_removed = removed_q;
          end
        end else begin
          // Pop the head; requeue it at the tail unless it is dropped.
          drop = head_match &&
                 ((op_q == cvl_pkg::OP_REMOVE_ALL) ||
                  ((op_q == cvl_pkg::OP_REMOVE_FIRST) && (removed_q == '0)));
          ctrl.shift = 1'b1;
          ctrl.write = !drop;
          tail       = count_m1[IW-1:0];
          wr_data    = cell_data[0];
          if (drop) begin
            count_d   = count_m1;
            removed_d = removed_q + CW'(1);
          end
          if ((op_q == cvl_pkg::OP_SEARCH) && head_match && !found_q) begin
            found_d = 1'b1;
            pos_d   = k_q;
          end
          k_d = k_q + CW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign tot_ext = {{cvl_pkg::TotalW{1'b0}}, count_d};
  assign rem_ext = {{cvl_pkg::TotalW{1'b0}}, res_removed};
  assign pos_ext = {{cvl_pkg::PosW{1'b0}}, res_pos};

  always_comb begin
    status_d = status_q;
    opos_d   = opos_q;
    orem_d   = orem_q;
    otot_d   = otot_q;
    ofull_d  = ofull_q;
    oempty_d = oempty_q;
    if (emit) begin
      status_d = res_status;
      opos_d   = pos_ext[cvl_pkg::PosW-1:0];
      orem_d   = rem_ext[cvl_pkg::TotalW-1:0];
      otot_d   = tot_ext[cvl_pkg::TotalW-1:0];
      ofull_d  = (count_d == CW'(CAPACITY));
      oempty_d = (count_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    k_q       <= k_d;
    removed_q <= removed_d;
    pos_q     <= pos_d;
    found_q   <= found_d;
    op_q      <= op_d;
    val_q     <= val_d;
    status_q  <= status_d;
    opos_q    <= opos_d;
    orem_q    <= orem_d;
    otot_q    <= otot_d;
    ofull_q   <= ofull_d;
    oempty_q  <= oempty_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign position_o      = opos_q;
  assign removed_count_o = orem_q;
  assign entry_total_o   = otot_q;
  assign is_full_o       = ofull_q;
  assign is_empty_o      = oempty_q;

  `CVL_ASSERT(a_count_range, 1'b1, count_q <= CW'(CAPACITY))
  `CVL_ASSERT(a_sweep_out_free, state_q == ST_SWEEP, !out_valid_q)
  `CVL_ASSERT(a_sweep_shrinks, state_q == ST_SWEEP, count_q <= n_q && k_q <= n_q)
  `CVL_ASSERT_NEXT(a_accept_progress, accept, out_valid_q || state_q == ST_SWEEP)

endmodule
